[rtl/core/vba_pkg.sv]
// ----------------------------------------------------------------------------
// vba_pkg
// Shared types and constants of the voxel bin accumulator.
// ----------------------------------------------------------------------------
package vba_pkg;

  localparam int unsigned MaxDimDefault   = 16;
  localparam int unsigned AccWidthDefault = 48;
  localparam int unsigned CfgIdxW         = 3;

  typedef enum logic [1:0] {
    OP_ACCUM    = 2'd0,
    OP_START    = 2'd1,
    OP_FINALIZE = 2'd2,
    OP_READ     = 2'd3
  } op_e;

  localparam logic [CfgIdxW-1:0] REG_ORIGIN_X = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_INV_PTCH = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_SIZE_X   = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_SIZE_Y   = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_SIZE_Z   = 3'd6;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;   // latch the input beat and start the index math
    logic mul;       // latch the products
    logic idx;       // latch the linear bin and range check
    logic rd;        // issue a memory read at the working address
    logic wr_acc;    // write the updated current bin
    logic sweep;     // one step of the commit / clear walk
    logic sweep_cm;  // the walk also adds into the cumulative store
    logic fin_sw;    // close a walk: counters and batch state
    logic set_act;   // after the walk: batch becomes active
    logic clr_act;   // after the walk: batch becomes inactive
    logic load_out;  // present the result beat
  } vba_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] op;
    logic       in_range;
    logic       active;
    logic       sum_pos;
    logic       sweep_last;
  } vba_sts_t;

endpackage

[rtl/core/vba_ctrl.sv]
// ----------------------------------------------------------------------------
// vba_ctrl
// Sequencer of the voxel bin accumulator.
// ----------------------------------------------------------------------------
module vba_ctrl
  import vba_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  logic     out_busy_i,
  input  vba_sts_t sts_i,
  output vba_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_IDX, S_RD, S_WAIT, S_UPD, S_SWEEP, S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   commit_q, commit_d;

  assign in_ready_o = (state_q == S_IDLE);

  // Next state and commands.
  always_comb begin
    state_d  = state_q;
    commit_d = commit_q;
    cmd_o    = '0;
    cmd_o.sweep_cm = commit_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d = S_IDX;
      end
      S_IDX: begin
        cmd_o.idx = 1'b1;
        if (sts_i.op == OP_START || sts_i.op == OP_FINALIZE) begin
          commit_d = sts_i.sum_pos &&
                     (sts_i.op == OP_FINALIZE || sts_i.active);
          state_d = S_SWEEP;
        end else begin
          state_d = S_RD;
        end
      end
      S_RD: begin
        cmd_o.rd = 1'b1;
        state_d = S_WAIT;
      end
      S_WAIT: begin
        state_d = S_UPD;
      end
      S_UPD: begin
        if (!out_busy_i) begin
          cmd_o.wr_acc   = (sts_i.op == OP_ACCUM) && sts_i.in_range;
          cmd_o.load_out = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_SWEEP: begin
        cmd_o.sweep = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_busy_i) begin
          cmd_o.fin_sw   = 1'b1;
          cmd_o.set_act  = (sts_i.op == OP_START);
          cmd_o.clr_act  = (sts_i.op == OP_FINALIZE);
          cmd_o.load_out = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      commit_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      commit_q <= commit_d;
    end
  end

endmodule

[rtl/core/vba_datapath.sv]
// ----------------------------------------------------------------------------
// vba_datapath
// Index arithmetic, bin stores, counters and the result register.
// ----------------------------------------------------------------------------
module vba_datapath
  import vba_pkg::*;
#(
  parameter int unsigned MAX_DIM   = MaxDimDefault,
  parameter int unsigned ACC_WIDTH = AccWidthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [31:0]         cfg_data_i,
  input  logic [1:0]          op_i,
  input  logic signed [31:0]  pos_x_i,
  input  logic signed [31:0]  pos_y_i,
  input  logic signed [31:0]  pos_z_i,
  input  logic signed [31:0]  contrib_i,
  input  logic [15:0]         batch_i,
  input  logic [11:0]         addr_i,
  input  vba_cmd_t            cmd_i,
  output vba_sts_t            sts_o,
  output logic                clr_busy_o,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic [191:0]        out_data_o
);

  localparam int unsigned DimW  = $clog2(MAX_DIM + 1);
  localparam int unsigned Depth = MAX_DIM * MAX_DIM * MAX_DIM;
  localparam int unsigned AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam logic signed [ACC_WIDTH-1:0] AccMax = {1'b0, {(ACC_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_WIDTH-1:0] AccMin = {1'b1, {(ACC_WIDTH-1){1'b0}}};

  function automatic logic signed [ACC_WIDTH-1:0] sat_add(
    input logic signed [ACC_WIDTH-1:0] a, input logic signed [ACC_WIDTH-1:0] b);
    logic signed [ACC_WIDTH:0] s;
    s = {a[ACC_WIDTH-1], a} + {b[ACC_WIDTH-1], b};
    if (s[ACC_WIDTH] != s[ACC_WIDTH-1]) begin
      return s[ACC_WIDTH] ? AccMin : AccMax;
    end
    return s[ACC_WIDTH-1:0];
  endfunction

  function automatic logic [DimW-1:0] clamp(input logic [4:0] s);
    if (32'(s) > MAX_DIM) begin
      return DimW'(MAX_DIM);
    end
    return DimW'(s);
  endfunction

  // Configuration registers.
  logic signed [31:0] org_q [3];
  logic [23:0]        ipitch_q;
  logic [4:0]         size_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_q[0] <= '0; org_q[1] <= '0; org_q[2] <= '0;
      ipitch_q <= 24'd65536;
      size_q[0] <= 5'd11; size_q[1] <= 5'd11; size_q[2] <= 5'd11;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ORIGIN_X: org_q[0] <= cfg_data_i;
        REG_ORIGIN_Y: org_q[1] <= cfg_data_i;
        REG_ORIGIN_Z: org_q[2] <= cfg_data_i;
        REG_INV_PTCH: ipitch_q <= cfg_data_i[23:0];
        REG_SIZE_X:   size_q[0] <= cfg_data_i[4:0];
        REG_SIZE_Y:   size_q[1] <= cfg_data_i[4:0];
        REG_SIZE_Z:   size_q[2] <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  // Input beat and differences.
  logic [1:0]                op_q;
  logic signed [32:0]        diff_q [3];
  logic signed [31:0]        contrib_q;
  logic [11:0]               addr_q;
  logic signed [57:0]        prod_q [3];
  logic [DimW-1:0]           sz_q [3];

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q      <= op_i;
      diff_q[0] <= 33'(pos_x_i) - 33'(org_q[0]);
      diff_q[1] <= 33'(pos_y_i) - 33'(org_q[1]);
      diff_q[2] <= 33'(pos_z_i) - 33'(org_q[2]);
      contrib_q <= contrib_i;
      addr_q    <= addr_i;
      for (int a = 0; a < 3; a++) begin
        sz_q[a] <= clamp(size_q[a]);
      end
    end
    if (cmd_i.mul) begin
      for (int a = 0; a < 3; a++) begin
        prod_q[a] <= diff_q[a] * $signed({1'b0, ipitch_q});
      end
    end
  end

  // Per-axis floor index and range check.
  logic [25:0] vox [3];
  logic        ok  [3];
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      vox[a] = prod_q[a][57:32];
      ok[a]  = !prod_q[a][57] && (vox[a] < 26'(sz_q[a]));
    end
  end

  // Linear bin index, registered.
  logic [AW-1:0] lin_d;
  logic [AW-1:0] bin_q;
  logic          inr_q;
  always_comb begin
    lin_d = AW'(32'(vox[0][DimW-1:0]) + 32'(sz_q[0]) *
            (32'(vox[1][DimW-1:0]) + 32'(sz_q[1]) * 32'(vox[2][DimW-1:0])));
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.idx) begin
      inr_q <= (op_q == OP_ACCUM) && ok[0] && ok[1] && ok[2];
      bin_q <= (op_q == OP_READ) ? AW'(addr_q) : lin_d;
    end
  end

  // Address of a read beyond the store.
  logic addr_oob;
  assign addr_oob = (32'(addr_q) >= Depth);

  // Bin stores. The walk counter also drives the clearing pass after reset.
  logic signed [ACC_WIDTH-1:0] cur_mem [Depth];
  logic signed [ACC_WIDTH-1:0] cum_mem [Depth];
  logic signed [ACC_WIDTH-1:0] cur_rd_q, cum_rd_q;
  logic [AW:0]   sw_q;       // walk read pointer
  logic [AW:0]   sw_wr_q;    // walk write pointer, one behind
  logic          sw_wv_q;
  logic          clr_q;
  logic          sw_done_q;

  assign clr_busy_o = clr_q;

  logic [AW-1:0] rd_addr;
  assign rd_addr = cmd_i.sweep ? sw_q[AW-1:0] : bin_q;

  logic signed [ACC_WIDTH-1:0] new_cur;
  assign new_cur = sat_add(cur_rd_q, ACC_WIDTH'(contrib_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd || cmd_i.sweep) begin
      cur_rd_q <= cur_mem[rd_addr];
      cum_rd_q <= cum_mem[rd_addr];
    end
    if (clr_q) begin
      cur_mem[sw_q[AW-1:0]] <= '0;
      cum_mem[sw_q[AW-1:0]] <= '0;
    end else if (sw_wv_q) begin
      cur_mem[sw_wr_q[AW-1:0]] <= '0;
      if (cmd_i.sweep_cm) begin
        cum_mem[sw_wr_q[AW-1:0]] <= sat_add(cum_rd_q, cur_rd_q);
      end
    end else if (cmd_i.wr_acc) begin
      cur_mem[bin_q] <= new_cur;
    end
  end

  // Walk control: reads run ahead of writes, through the registered write pointer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_q      <= '0;
      sw_wr_q   <= '0;
      sw_wv_q   <= 1'b0;
      clr_q     <= 1'b1;
      sw_done_q <= 1'b0;
    end else if (clr_q) begin
      sw_q <= sw_q + 1'b1;
      if (32'(sw_q) == Depth - 1) begin
        clr_q <= 1'b0;
        sw_q  <= '0;
      end
    end else begin
      sw_wv_q <= cmd_i.sweep && !sw_done_q;
      sw_wr_q <= sw_q;
      if (cmd_i.sweep && !sw_done_q) begin
        if (32'(sw_q) == Depth - 1) begin
          sw_done_q <= 1'b1;
        end else begin
          sw_q <= sw_q + 1'b1;
        end
      end else if (!cmd_i.sweep) begin
        sw_q      <= '0;
        sw_done_q <= 1'b0;
      end
    end
  end

  // Batch state and counters.
  logic signed [ACC_WIDTH-1:0] bsum_q;
  logic        active_q;
  logic [15:0] bid_q, done_q;
  logic [31:0] hits_q, drops_q;
  logic        cm_flag;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bsum_q <= '0; active_q <= 1'b0; bid_q <= '0; done_q <= '0;
      hits_q <= '0; drops_q <= '0;
    end else begin
      if (cmd_i.load_out && op_q == OP_ACCUM) begin
        if (inr_q) begin
          bsum_q <= sat_add(bsum_q, new_cur - cur_rd_q);
          if (hits_q != '1) hits_q <= hits_q + 1'b1;
        end else if (drops_q != '1) begin
          drops_q <= drops_q + 1'b1;
        end
      end
      if (cmd_i.fin_sw) begin
        bsum_q <= '0;
        if (cmd_i.sweep_cm && done_q != '1) done_q <= done_q + 1'b1;
      end
      if (cmd_i.set_act) begin
        active_q <= 1'b1;
        bid_q    <= batch_i;
      end
      if (cmd_i.clr_act) active_q <= 1'b0;
    end
  end

  assign cm_flag = cmd_i.fin_sw && cmd_i.sweep_cm;

  // Result register with a simple handshake.
  logic         ov_q;
  logic [191:0] od_q;
  logic [47:0]  cur_o, cum_o;
  logic [15:0]  done_o;
  always_comb begin
    cur_o = '0; cum_o = '0;
    if (op_q == OP_ACCUM && inr_q) begin
      cur_o = 48'(new_cur); cum_o = 48'(cum_rd_q);
    end else if (op_q == OP_READ && !addr_oob) begin
      cur_o = 48'(cur_rd_q); cum_o = 48'(cum_rd_q);
    end
    done_o = (cm_flag && done_q != '1) ? done_q + 1'b1 : done_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      ov_q <= 1'b1;
    end else if (out_ready_i) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      od_q <= {2'd0, drops_q + 32'(op_q == OP_ACCUM && !inr_q && drops_q != '1),
               hits_q + 32'(op_q == OP_ACCUM && inr_q && hits_q != '1),
               done_o, cm_flag, cum_o, cur_o,
               (op_q == OP_READ) ? addr_q : (inr_q ? 12'(bin_q) : 12'd0),
               (op_q == OP_ACCUM) && inr_q};
    end
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = od_q;

  assign sts_o.op         = op_q;
  assign sts_o.in_range   = inr_q;
  assign sts_o.active     = active_q;
  assign sts_o.sum_pos    = !bsum_q[ACC_WIDTH-1] && (bsum_q != '0);
  assign sts_o.sweep_last = sw_done_q;

`ifndef SYNTHESIS
  a_no_acc_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.sweep |-> !cmd_i.wr_acc) else $error("write during walk");
  a_sum_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.fin_sw |=> bsum_q == '0) else $error("batch sum not cleared");
  a_no_clr_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> !cmd_i.capture) else $error("beat taken during clearing");
`endif

endmodule

[rtl/core/voxel_bin_accumulator_top.sv]
// ----------------------------------------------------------------------------
// voxel_bin_accumulator_top
// Voxel grid histogram tally with batch commits.
// ----------------------------------------------------------------------------
// An accumulate or read beat steps through capture, multiply, index, memory
// read, read wait and update, and may wait on output back-pressure. Start
// batch and finalize walk every bin. After reset a clearing pass over every
// bin runs before the first beat is accepted; configuration should be
// written only while no beat is in flight.
module voxel_bin_accumulator_top
  import vba_pkg::*;
#(
  parameter int unsigned MAX_DIM   = MaxDimDefault,
  parameter int unsigned ACC_WIDTH = AccWidthDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [2:0]   cfg_index_i,
  input  logic [31:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // operation[1:0]
  input  logic [1:0]   s_axis_tuser,
  // pos_x, pos_y, pos_z, contribution, batch_number, bin_address, zero pad
  input  logic [159:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // in_range, bin_index, current_value, cumulative_value, batch_committed,
  // committed_batches, hit_count, dropped_count, zero pad
  output logic [191:0] m_axis_tdata
);

  vba_cmd_t cmd;
  vba_sts_t sts;
  logic     rdy, clr_busy;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = rdy && !clr_busy;

  vba_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid && !clr_busy),
    .in_ready_o (rdy),
    .out_busy_i (m_axis_tvalid && !m_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  vba_datapath #(.MAX_DIM(MAX_DIM), .ACC_WIDTH(ACC_WIDTH)) u_dp (
    .clk_i, .rst_ni,
    .cfg_we_i    (cfg_valid_i),
    .cfg_idx_i   (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .op_i        (s_axis_tuser),
    .pos_x_i     (s_axis_tdata[31:0]),
    .pos_y_i     (s_axis_tdata[63:32]),
    .pos_z_i     (s_axis_tdata[95:64]),
    .contrib_i   (s_axis_tdata[127:96]),
    .batch_i     (s_axis_tdata[143:128]),
    .addr_i      (s_axis_tdata[155:144]),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .clr_busy_o  (clr_busy),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata)
  );

endmodule

[sim/tb_voxel_bin_accumulator_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_voxel_bin_accumulator_top
// Self-checking testbench of the voxel bin accumulator.
// ----------------------------------------------------------------------------
// A directed table covers reset contents, grid edges, extreme values and every
// operation. It is followed by random phases under several grid settings.
// A behavioral tally model in this file predicts every result beat but those of
// typed rows, which carry their own. Both stream sides see random gaps and stalls.
module tb_voxel_bin_accumulator_top;
  import vba_pkg::*;

  localparam int unsigned Depth = MaxDimDefault * MaxDimDefault * MaxDimDefault;
  localparam longint AccMax = (longint'(1) <<< 47) - 1;
  localparam longint AccMin = -AccMax - 1;

  typedef struct packed {
    logic [31:0] dropped;
    logic [31:0] hits;
    logic [15:0] batches;
    logic        committed;
    logic [47:0] cum_val;
    logic [47:0] cur_val;
    logic [11:0] bin;
    logic        in_range;
  } tally_t;

  typedef struct {
    op_e         op;
    logic [31:0] px, py, pz, contrib;
    logic [15:0] batch;
    logic [11:0] addr;
    bit          typed;
    tally_t      want;
  } beat_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [2:0]   cfg_index_i = '0;
  logic [31:0]  cfg_data_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [1:0]   s_axis_tuser = '0;
  logic [159:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [191:0] m_axis_tdata;

  voxel_bin_accumulator_top i_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Tally model state and its copy of the grid settings.
  longint      org_x, org_y, org_z;
  longint      inv_pitch;
  int unsigned dim_x, dim_y, dim_z;
  longint      cur_bins[Depth];
  longint      cum_bins[Depth];
  longint      run_sum;
  bit          batch_open;
  logic [15:0] batches_done;
  logic [31:0] hit_cnt, drop_cnt;

  tally_t      pending[$];
  int unsigned errors = 0;
  int unsigned beats_sent = 0, beats_seen = 0, walks = 0;

  function automatic longint sat_add(longint a, longint b);
    if (b > 0 && a > AccMax - b) return AccMax;
    if (b < 0 && a < AccMin - b) return AccMin;
    return a + b;
  endfunction

  function automatic int unsigned clamp_dim(int unsigned s);
    return (s > MaxDimDefault) ? MaxDimDefault : s;
  endfunction

  // Voxel index along one axis, or -1 when outside the grid.
  function automatic longint axis_index(logic [31:0] pos, longint org, int unsigned dim);
    longint d, p, idx;
    d = longint'(signed'(pos)) - org;
    p = d * inv_pitch;
    if (p < 0) return -1;
    idx = p >>> 32;
    return (idx >= dim) ? -1 : idx;
  endfunction

  function automatic bit close_batch();
    bit done;
    done = run_sum > 0;
    if (done) begin
      foreach (cum_bins[k]) cum_bins[k] = sat_add(cum_bins[k], cur_bins[k]);
      if (batches_done != 16'hFFFF) batches_done++;
    end
    foreach (cur_bins[k]) cur_bins[k] = 0;
    run_sum = 0;
    return done;
  endfunction

  function automatic tally_t tally_step(beat_t b);
    tally_t r;
    longint ix, iy, iz, old, nv, k;
    int unsigned sx, sy, sz;
    r = '0;
    case (b.op)
      OP_ACCUM: begin
        sx = clamp_dim(dim_x);
        sy = clamp_dim(dim_y);
        sz = clamp_dim(dim_z);
        ix = axis_index(b.px, org_x, sx);
        iy = axis_index(b.py, org_y, sy);
        iz = axis_index(b.pz, org_z, sz);
        if (ix >= 0 && iy >= 0 && iz >= 0) begin
          k = ix + sx * (iy + sy * iz);
          old = cur_bins[k];
          nv = sat_add(old, longint'(signed'(b.contrib)));
          cur_bins[k] = nv;
          run_sum = sat_add(run_sum, nv - old);
          if (hit_cnt != '1) hit_cnt++;
          r.in_range = 1'b1;
          r.bin = k[11:0];
          r.cur_val = nv[47:0];
          r.cum_val = cum_bins[k][47:0];
        end else if (drop_cnt != '1) begin
          drop_cnt++;
        end
      end
      OP_START: begin
        if (batch_open) begin
          r.committed = close_batch();
        end else begin
          foreach (cur_bins[j]) cur_bins[j] = 0;
          run_sum = 0;
        end
        batch_open = 1'b1;
      end
      OP_FINALIZE: begin
        r.committed = close_batch();
        batch_open = 1'b0;
      end
      default: begin
        r.bin = b.addr;
        r.cur_val = cur_bins[b.addr][47:0];
        r.cum_val = cum_bins[b.addr][47:0];
      end
    endcase
    r.batches = batches_done;
    r.hits = hit_cnt;
    r.dropped = drop_cnt;
    return r;
  endfunction

  function automatic void model_config(logic [2:0] idx, logic [31:0] val);
    case (idx)
      REG_ORIGIN_X: org_x = longint'(signed'(val));
      REG_ORIGIN_Y: org_y = longint'(signed'(val));
      REG_ORIGIN_Z: org_z = longint'(signed'(val));
      REG_INV_PTCH: inv_pitch = longint'(val[23:0]);
      REG_SIZE_X:   dim_x = 32'(val[4:0]);
      REG_SIZE_Y:   dim_y = 32'(val[4:0]);
      REG_SIZE_Z:   dim_z = 32'(val[4:0]);
      default: ;
    endcase
  endfunction

  // Short gaps mostly, now and then a long one, often none.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Result side stall pattern: runs of full readiness and runs of stalls.
  int unsigned ready_mode = 0;
  always @(posedge clk_i) begin
    if ($urandom_range(0, 63) == 0) ready_mode <= $urandom_range(0, 2);
    case (ready_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= ($urandom_range(0, 3) != 0);
      default: m_axis_tready <= ($urandom_range(0, 9) == 0);
    endcase
  end

  // Result checker.
  always @(posedge clk_i) begin
    tally_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[189:0];
      beats_seen++;
      if (pending.size() == 0) begin
        $display("%0t: result beat with nothing expected: %h", $time, got);
        errors++;
      end else begin
        want = pending.pop_front();
        if (got.in_range !== want.in_range) begin
          $display("%0t: in_range exp %0d got %0d", $time, want.in_range, got.in_range);
          errors++;
        end
        if (got.bin !== want.bin) begin
          $display("%0t: bin_index exp %0d got %0d", $time, want.bin, got.bin);
          errors++;
        end
        if (got.cur_val !== want.cur_val) begin
          $display("%0t: current_value exp %h got %h", $time, want.cur_val, got.cur_val);
          errors++;
        end
        if (got.cum_val !== want.cum_val) begin
          $display("%0t: cumulative_value exp %h got %h", $time, want.cum_val,
                   got.cum_val);
          errors++;
        end
        if (got.committed !== want.committed) begin
          $display("%0t: batch_committed exp %0d got %0d", $time, want.committed,
                   got.committed);
          errors++;
        end
        if (got.batches !== want.batches) begin
          $display("%0t: committed_batches exp %0d got %0d", $time, want.batches,
                   got.batches);
          errors++;
        end
        if (got.hits !== want.hits) begin
          $display("%0t: hit_count exp %0d got %0d", $time, want.hits, got.hits);
          errors++;
        end
        if (got.dropped !== want.dropped) begin
          $display("%0t: dropped_count exp %0d got %0d", $time, want.dropped,
                   got.dropped);
          errors++;
        end
      end
    end
  end

  // Drive one beat; valid stays high into the next beat when no gap follows.
  task automatic send_beat(beat_t b);
    tally_t exp_val;
    int unsigned gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= b.op;
    s_axis_tdata <= {4'd0, b.addr, b.batch, b.contrib, b.pz, b.py, b.px};
    do @(posedge clk_i); while (!s_axis_tready);
    exp_val = tally_step(b);
    pending.insert(pending.size(), b.typed ? b.want : exp_val);
    beats_sent++;
    if (b.op == OP_START || b.op == OP_FINALIZE) walks++;
    gap = pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_regs(logic [31:0] vals[7]);
    for (int i = 0; i < 7; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= i[2:0];
      cfg_data_i <= vals[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      model_config(i[2:0], vals[i]);
    end
    cfg_valid_i <= 1'b0;
  endtask

  // A position that usually lands inside the grid along one axis.
  function automatic logic [31:0] aim(longint org, int unsigned dim);
    longint i, d;
    if (inv_pitch == 0 || clamp_dim(dim) == 0) return $urandom;
    i = $urandom_range(0, clamp_dim(dim) - 1);
    d = ((i <<< 32) + longint'($urandom)) / inv_pitch;
    return 32'(org + d);
  endfunction

  function automatic beat_t random_beat();
    beat_t b;
    int unsigned r;
    r = $urandom_range(0, 999);
    b.px = $urandom;
    b.py = $urandom;
    b.pz = $urandom;
    b.contrib = $urandom;
    b.batch = 16'($urandom);
    b.addr = 12'($urandom);
    b.typed = 1'b0;
    b.want = '0;
    if (r < 30) begin
      b.op = OP_START;
    end else if (r < 45) begin
      b.op = OP_FINALIZE;
    end else if (r < 150) begin
      b.op = OP_READ;
      if ($urandom_range(0, 1) != 0) b.addr = 12'($urandom_range(0, 255));
    end else begin
      b.op = OP_ACCUM;
      if (r >= 250) begin
        b.px = aim(org_x, dim_x);
        b.py = aim(org_y, dim_y);
        b.pz = aim(org_z, dim_z);
        if ($urandom_range(0, 3) != 0) b.contrib = $urandom_range(0, 32'h0004_0000);
      end
    end
    return b;
  endfunction

  function automatic beat_t row(op_e op, logic [31:0] px, logic [31:0] py,
                                logic [31:0] pz, logic [31:0] c, logic [15:0] bn,
                                logic [11:0] a);
    beat_t b;
    b.op = op;
    b.px = px;
    b.py = py;
    b.pz = pz;
    b.contrib = c;
    b.batch = bn;
    b.addr = a;
    b.typed = 1'b0;
    b.want = '0;
    return b;
  endfunction

  // Directed table, walked in order under the reset settings.
  beat_t directed[$];
  logic [31:0] phase_regs[6][7] = '{
    '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h00FF_FFFF, 32'd16, 32'd16, 32'd16},
    '{32'h7FFF_FFFF, 32'hFFFF_0000, 32'h0001_0000, 32'h0002_0000, 32'd31, 32'd1, 32'd16},
    '{32'd0, 32'd0, 32'd0, 32'd0, 32'd4, 32'd4, 32'd4},
    '{32'hFFFF_8000, 32'h0000_8000, 32'd0, 32'h0000_8000, 32'd0, 32'd5, 32'd5},
    '{32'hFFFE_0000, 32'hFFFE_0000, 32'hFFFE_0000, 32'h0001_0000, 32'd3, 32'd3, 32'd2},
    '{32'd0, 32'd0, 32'd0, 32'h0001_0000, 32'd11, 32'd11, 32'd11}
  };

  initial begin
    beat_t b;
    org_x = 0;
    org_y = 0;
    org_z = 0;
    inv_pitch = 65536;
    dim_x = 11;
    dim_y = 11;
    dim_z = 11;
    foreach (cur_bins[k]) begin
      cur_bins[k] = 0;
      cum_bins[k] = 0;
    end
    run_sum = 0;
    batch_open = 1'b0;
    batches_done = '0;
    hit_cnt = '0;
    drop_cnt = '0;

    // Reset contents, then edges of the grid and extreme values.
    b = row(OP_READ, 0, 0, 0, 0, 0, 12'd0);
    b.typed = 1'b1;
    directed.insert(directed.size(), b);
    b = row(OP_READ, 0, 0, 0, 0, 0, 12'hFFF);
    b.typed = 1'b1;
    b.want.bin = 12'hFFF;
    directed.insert(directed.size(), b);
    b = row(OP_ACCUM, 0, 0, 0, 32'h0001_0000, 0, 0);
    b.typed = 1'b1;
    b.want.in_range = 1'b1;
    b.want.cur_val = 48'h1_0000;
    b.want.hits = 32'd1;
    directed.insert(directed.size(), b);
    b = row(OP_ACCUM, 32'hFFFF_FFFF, 0, 0, 32'h0001_0000, 0, 0);
    b.typed = 1'b1;
    b.want.hits = 32'd1;
    b.want.dropped = 32'd1;
    directed.insert(directed.size(), b);
    directed.insert(directed.size(), row(OP_START, 0, 0, 0, 0, 16'hFFFF, 0));
    directed.insert(directed.size(), row(OP_ACCUM, 32'h000A_FFFF, 32'h000A_FFFF,
                                         32'h000A_FFFF, 32'h7FFF_FFFF, 0, 0));
    directed.insert(directed.size(), row(OP_ACCUM, 32'h000A_FFFF, 32'h000A_FFFF,
                                         32'h000A_FFFF, 32'h7FFF_FFFF, 0, 0));
    directed.insert(directed.size(), row(OP_ACCUM, 32'h000B_0000, 0, 0, 32'h1, 0, 0));
    directed.insert(directed.size(), row(OP_ACCUM, 32'h7FFF_FFFF, 32'h8000_0000, 0,
                                         32'h1, 0, 0));
    directed.insert(directed.size(), row(OP_ACCUM, 32'h0003_8000, 32'h0002_0000,
                                         32'h0001_0000, 32'h8000_0000, 0, 0));
    directed.insert(directed.size(), row(OP_ACCUM, 32'h0001_0000, 32'h0001_0000,
                                         32'h0001_0000, 32'hFFFF_FFFF, 0, 0));
    directed.insert(directed.size(), row(OP_READ, 0, 0, 0, 0, 0, 12'd1330));
    directed.insert(directed.size(), row(OP_START, 0, 0, 0, 0, 16'h0001, 0));
    directed.insert(directed.size(), row(OP_READ, 0, 0, 0, 0, 0, 12'd1330));
    directed.insert(directed.size(), row(OP_ACCUM, 0, 0, 0, 32'hFFFF_0000, 0, 0));
    directed.insert(directed.size(), row(OP_START, 0, 0, 0, 0, 16'h0002, 0));
    directed.insert(directed.size(), row(OP_ACCUM, 32'h0005_0000, 32'h0005_0000,
                                         32'h0005_0000, 32'h0000_0100, 0, 0));
    directed.insert(directed.size(), row(OP_FINALIZE, 0, 0, 0, 0, 0, 0));
    directed.insert(directed.size(), row(OP_FINALIZE, 0, 0, 0, 0, 0, 0));
    directed.insert(directed.size(), row(OP_READ, 0, 0, 0, 0, 0, 12'd665));
    directed.insert(directed.size(), row(OP_READ, 0, 0, 0, 0, 0, 12'd0));

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed[i]) send_beat(directed[i]);

    // Random phases, each under fresh settings written while idle.
    foreach (phase_regs[p]) begin
      drain();
      write_regs(phase_regs[p]);
      repeat (70) send_beat(random_beat());
    end

    drain();
    $display("Sent %0d beats and checked %0d results, %0d of them bin walks,",
             beats_sent, beats_seen, walks);
    $display("over seven grid settings including extreme origins, pitches and sizes.");
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #100ms;
    $display("FAILURE");
    $finish;
  end

endmodule
